### rtl/psb_pkg.sv
// Shared constants, payload types and control structs for the palette sprite blitter.
package psb_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int MAX_SCALE       = 4;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int SCALE_W         = 3;
    localparam int CNT_W           = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int COLOR_W         = 16;
    localparam int COORD_W         = 16;
    localparam int DIM_W           = 8;
    localparam int CP_W            = 7;
    localparam int MODE_W          = 4;
    localparam int OP_W            = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [OP_W-1:0] OP_PAL     = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd5;

    localparam int MODE_SHOW      = 0;
    localparam int MODE_FLIP_X    = 1;
    localparam int MODE_FLIP_Y    = 2;
    localparam int MODE_TRANSPOSE = 3;

    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_HI   = 2'd1;
    localparam logic [1:0] RD_LO   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PAL_AW-1:0]  pal_index;
        logic [COLOR_W-1:0] pal_color;
        logic [DIM_W-1:0]   pixel_byte;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } wr_t;

    typedef struct packed {
        logic       load_item;
        logic [1:0] rd_sel;
        logic       calc_hi;
        logic       calc_lo;
        logic       cap_zero;
        logic       cap_hi;
        logic       cap_lo;
        logic       emit;
        logic       start_lo;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] item_op;
        logic            draw_en;
        logic            hi_draw;
        logic            lo_draw;
        logic            out_free;
        logic            pix_done;
        logic            byte_done;
    } sts_t;

endpackage

### rtl/palette_sprite_blitter.sv
// Top level: 4bpp palette sprite blitter producing scaled, flipped pixel writes.
// Palette loads, restarts and bytes with drawing off are accepted back to back.
// A drawn byte reads the palette (one shared RAM read port reads entry 0, the high
// and the low nibble), then issues 0 to 2*scale*scale writes, scale capped at MAX_SCALE.
// Writes follow states RD_Z, RD_HI, RD_LO and CMP; output stalls hold the sequencer.
// rst_n clears configuration, position and control; palette contents are not cleared.
module palette_sprite_blitter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  psb_pkg::item_t                 item_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [psb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psb_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           wr_valid,
    input  logic                           wr_ready,
    output psb_pkg::wr_t                   wr_data
);

    psb_pkg::cmd_t cmd;
    psb_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    psb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    psb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .item_data (item_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr_data   (wr_data)
    );

endmodule

### rtl/psb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/psb_datapath.sv
// Datapath: configuration, sprite position, palette lookup, write generation and output register.
module psb_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  psb_pkg::cmd_t                        cmd,
    output psb_pkg::sts_t                        sts,
    input  psb_pkg::item_t                       item_data,
    input  logic                                 cfg_valid,
    input  logic [psb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psb_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 wr_valid,
    input  logic                                 wr_ready,
    output psb_pkg::wr_t                         wr_data
);

    logic [psb_pkg::COORD_W-1:0] origin_x_reg;
    logic [psb_pkg::COORD_W-1:0] origin_y_reg;
    logic [psb_pkg::DIM_W-1:0]   width_reg;
    logic [psb_pkg::DIM_W-1:0]   height_reg;
    logic [psb_pkg::SCALE_W-1:0] scale_reg;
    logic [psb_pkg::MODE_W-1:0]  mode_reg;

    logic [psb_pkg::CP_W-1:0]    cp_reg;
    logic [psb_pkg::DIM_W-1:0]   row_reg;

    logic [psb_pkg::DIM_W-1:0]   byte_reg;
    logic [psb_pkg::DIM_W-1:0]   col_reg;
    logic [psb_pkg::DIM_W-1:0]   rowc_reg;
    logic [psb_pkg::SCALE_W-1:0] s_reg;

    logic [psb_pkg::COORD_W-1:0] xbase_hi_reg;
    logic [psb_pkg::COORD_W-1:0] xbase_lo_reg;
    logic [psb_pkg::COORD_W-1:0] ybase_reg;
    logic [psb_pkg::COLOR_W-1:0] zero_reg;
    logic [psb_pkg::COLOR_W-1:0] hi_color_reg;
    logic [psb_pkg::COLOR_W-1:0] lo_color_reg;
    logic                        lo_draw_reg;
    logic                        sel_lo_reg;
    logic [psb_pkg::CNT_W-1:0]   k_reg;
    logic [psb_pkg::CNT_W-1:0]   l_reg;

    logic                        out_valid_reg;
    psb_pkg::wr_t                out_reg;

    logic [psb_pkg::PAL_AW-1:0]  ram_raddr;
    logic [psb_pkg::COLOR_W-1:0] ram_rdata;
    logic                        ram_we;

    logic [psb_pkg::CP_W-1:0]    pairs;
    logic [psb_pkg::DIM_W-1:0]   cp_inc;
    logic [psb_pkg::DIM_W:0]     row_inc;
    logic                        wrap_col;
    logic                        wrap_row;
    logic [psb_pkg::SCALE_W-1:0] s_eff;
    logic [psb_pkg::SCALE_W-1:0] s_dec;
    logic [psb_pkg::CNT_W-1:0]   s_m1;
    logic                        pix_done;
    logic                        byte_done;
    logic                        out_free;
    logic [psb_pkg::COORD_W-1:0] xp;
    logic [psb_pkg::COORD_W-1:0] yp;
    logic                        tr;

    function automatic logic [psb_pkg::COORD_W-1:0] place(
        input logic [psb_pkg::COORD_W-1:0] origin,
        input logic [psb_pkg::DIM_W-1:0]   size,
        input logic [psb_pkg::DIM_W-1:0]   pos,
        input logic                        flip,
        input logic [psb_pkg::SCALE_W-1:0] s
    );
        logic [psb_pkg::COORD_W-1:0] p;
        logic [psb_pkg::COORD_W-1:0] prod;
        p = flip ? (psb_pkg::COORD_W'(size) - psb_pkg::COORD_W'(1) - psb_pkg::COORD_W'(pos))
                 : psb_pkg::COORD_W'(pos);
        prod = p * psb_pkg::COORD_W'(s);
        return origin + prod;
    endfunction

    // Palette store
    assign ram_we = cmd.load_item && (item_data.op == psb_pkg::OP_PAL);

    always_comb
    begin
        unique case (cmd.rd_sel)
            psb_pkg::RD_HI: ram_raddr = byte_reg[psb_pkg::DIM_W-1:psb_pkg::PAL_AW];
            psb_pkg::RD_LO: ram_raddr = byte_reg[psb_pkg::PAL_AW-1:0];
            default:        ram_raddr = '0;
        endcase
    end

    psb_ram #(
        .WIDTH (psb_pkg::COLOR_W),
        .DEPTH (psb_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_data.pal_index),
        .wdata (item_data.pal_color),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Position advance
    assign pairs    = width_reg[psb_pkg::DIM_W-1:1];
    assign cp_inc   = psb_pkg::DIM_W'(cp_reg) + psb_pkg::DIM_W'(1);
    assign row_inc  = (psb_pkg::DIM_W + 1)'(row_reg) + (psb_pkg::DIM_W + 1)'(1);
    assign wrap_col = (pairs == '0) || (cp_inc >= psb_pkg::DIM_W'(pairs));
    assign wrap_row = (height_reg == '0) || (row_inc >= (psb_pkg::DIM_W + 1)'(height_reg));
    assign s_eff    = (scale_reg > psb_pkg::SCALE_W'(psb_pkg::MAX_SCALE))
                      ? psb_pkg::SCALE_W'(psb_pkg::MAX_SCALE) : scale_reg;

    assign s_dec     = s_reg - psb_pkg::SCALE_W'(1);
    assign s_m1      = s_dec[psb_pkg::CNT_W-1:0];
    assign pix_done  = (k_reg == s_m1) && (l_reg == s_m1);
    assign byte_done = pix_done && (sel_lo_reg || !lo_draw_reg);
    assign out_free  = !out_valid_reg || wr_ready;
    assign tr        = mode_reg[psb_pkg::MODE_TRANSPOSE];
    assign xp        = (sel_lo_reg ? xbase_lo_reg : xbase_hi_reg) + psb_pkg::COORD_W'(k_reg);
    assign yp        = ybase_reg + psb_pkg::COORD_W'(l_reg);

    always_comb
    begin
        sts.item_op   = item_data.op;
        sts.draw_en   = mode_reg[psb_pkg::MODE_SHOW] && (scale_reg != '0);
        sts.hi_draw   = hi_color_reg != zero_reg;
        sts.lo_draw   = ram_rdata != zero_reg;
        sts.out_free  = out_free;
        sts.pix_done  = pix_done;
        sts.byte_done = byte_done;
    end

    // Configuration and sprite position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            scale_reg    <= '0;
            mode_reg     <= '0;
            cp_reg       <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    psb_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                    psb_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    psb_pkg::REG_WIDTH:    width_reg    <= cfg_data[psb_pkg::DIM_W-1:0];
                    psb_pkg::REG_HEIGHT:   height_reg   <= cfg_data[psb_pkg::DIM_W-1:0];
                    psb_pkg::REG_SCALE:    scale_reg    <= cfg_data[psb_pkg::SCALE_W-1:0];
                    psb_pkg::REG_MODE:     mode_reg     <= cfg_data[psb_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load_item && (item_data.op == psb_pkg::OP_RESTART))
            begin
                cp_reg  <= '0;
                row_reg <= '0;
            end
            else if (cmd.load_item && (item_data.op == psb_pkg::OP_BYTE))
            begin
                if (wrap_col)
                begin
                    cp_reg  <= '0;
                    row_reg <= wrap_row ? '0 : row_inc[psb_pkg::DIM_W-1:0];
                end
                else
                begin
                    cp_reg <= cp_inc[psb_pkg::CP_W-1:0];
                end
            end
        end
    end

    // Per-byte working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            byte_reg <= item_data.pixel_byte;
            col_reg  <= {cp_reg, 1'b0};
            rowc_reg <= row_reg;
            s_reg    <= s_eff;
        end
        if (cmd.calc_hi)
        begin
            xbase_hi_reg <= place(origin_x_reg, width_reg, col_reg,
                                  mode_reg[psb_pkg::MODE_FLIP_X], s_reg);
            ybase_reg    <= place(origin_y_reg, height_reg, rowc_reg,
                                  mode_reg[psb_pkg::MODE_FLIP_Y], s_reg);
        end
        if (cmd.calc_lo)
        begin
            xbase_lo_reg <= place(origin_x_reg, width_reg, {col_reg[psb_pkg::DIM_W-1:1], 1'b1},
                                  mode_reg[psb_pkg::MODE_FLIP_X], s_reg);
        end
        if (cmd.cap_zero)
        begin
            zero_reg <= ram_rdata;
        end
        if (cmd.cap_hi)
        begin
            hi_color_reg <= ram_rdata;
        end
        if (cmd.cap_lo)
        begin
            lo_color_reg <= ram_rdata;
            lo_draw_reg  <= sts.lo_draw;
            sel_lo_reg   <= !sts.hi_draw;
            k_reg        <= '0;
            l_reg        <= '0;
        end
        else if (cmd.start_lo)
        begin
            sel_lo_reg <= 1'b1;
            k_reg      <= '0;
            l_reg      <= '0;
        end
        else if (cmd.emit)
        begin
            if (l_reg == s_m1)
            begin
                l_reg <= '0;
                k_reg <= k_reg + psb_pkg::CNT_W'(1);
            end
            else
            begin
                l_reg <= l_reg + psb_pkg::CNT_W'(1);
            end
        end
        if (cmd.emit)
        begin
            out_reg.screen_x <= tr ? yp : xp;
            out_reg.screen_y <= tr ? xp : yp;
            out_reg.color    <= sel_lo_reg ? lo_color_reg : hi_color_reg;
            out_reg.last     <= byte_done;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (wr_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign wr_valid = out_valid_reg;
    assign wr_data  = out_reg;

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("write issued while output register is occupied");

    a_emit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (k_reg <= s_m1) && (l_reg <= s_m1))
        else $error("replication counter beyond scale");

endmodule

### rtl/psb_ctrl.sv
// Controller: sequences palette lookups and pixel write issue for each sprite byte.
module psb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  psb_pkg::sts_t sts,
    output psb_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_Z  = 3'd1;
    localparam logic [2:0] S_RD_HI = 3'd2;
    localparam logic [2:0] S_RD_LO = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = psb_pkg::RD_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = item_valid;
                if (item_valid && (sts.item_op == psb_pkg::OP_BYTE) && sts.draw_en)
                begin
                    state_next = S_RD_Z;
                end
            end
            S_RD_Z:
            begin
                cmd.rd_sel  = psb_pkg::RD_ZERO;
                cmd.calc_hi = 1'b1;
                state_next  = S_RD_HI;
            end
            S_RD_HI:
            begin
                cmd.rd_sel   = psb_pkg::RD_HI;
                cmd.cap_zero = 1'b1;
                cmd.calc_lo  = 1'b1;
                state_next   = S_RD_LO;
            end
            S_RD_LO:
            begin
                cmd.rd_sel = psb_pkg::RD_LO;
                cmd.cap_hi = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cap_lo = 1'b1;
                state_next = (sts.hi_draw || sts.lo_draw) ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.pix_done)
                begin
                    if (sts.byte_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.start_lo = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_byte_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && sts.out_free && sts.byte_done) |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after final write");

    a_byte_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && sts.item_op == psb_pkg::OP_BYTE && sts.draw_en)
        |=> state_reg == S_RD_Z)
        else $error("drawn byte did not start palette lookup");

endmodule

### sim/tb_palette_sprite_blitter.sv
// Self-checking testbench for the palette sprite blitter: directed and random sprite streams.
module tb_palette_sprite_blitter;

    localparam logic [psb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [3:0]      TRANSPARENT_IDX = 4'd0;
    localparam int              DRAIN_CYCLES    = 16;
    localparam int              MAX_GAP         = 17;
    localparam int              PHASES          = 6;
    localparam int              PHASE_ITEMS     = 68;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           item_valid = 1'b0;
    logic                           item_ready;
    psb_pkg::item_t                 item_data = '0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [psb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [psb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           wr_valid;
    logic                           wr_ready = 1'b0;
    psb_pkg::wr_t                   wr_data;

    // shadow configuration and sprite position
    logic [15:0] cfg_origin_x = '0;
    logic [15:0] cfg_origin_y = '0;
    logic [7:0]  cfg_width = '0;
    logic [7:0]  cfg_height = '0;
    logic [2:0]  cfg_scale = '0;
    logic [3:0]  cfg_mode = '0;
    logic [15:0] palette_copy [psb_pkg::PALETTE_ENTRIES];
    logic [6:0]  cur_col_pair = '0;
    logic [7:0]  cur_row = '0;

    psb_pkg::wr_t writes_due [$];
    psb_pkg::wr_t want_w;
    int  mismatches = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    palette_sprite_blitter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .wr_data    (wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h want %h", what, got, want);
    endtask

    task automatic expand_pixel(input logic [31:0] col, input logic [31:0] row,
                                input logic [31:0] s, input logic [15:0] colr);
        logic [31:0] c;
        logic [31:0] r;
        logic [31:0] xs;
        logic [31:0] ys;
        int          k;
        int          l;
        psb_pkg::wr_t w;
        c = cfg_mode[psb_pkg::MODE_FLIP_X] ? {24'd0, cfg_width} - 32'd1 - col : col;
        r = cfg_mode[psb_pkg::MODE_FLIP_Y] ? {24'd0, cfg_height} - 32'd1 - row : row;
        for (k = 0; k < int'(s); k++)
        begin
            xs = {16'd0, cfg_origin_x} + c * s + k;
            for (l = 0; l < int'(s); l++)
            begin
                ys = {16'd0, cfg_origin_y} + r * s + l;
                w.screen_x = cfg_mode[psb_pkg::MODE_TRANSPOSE] ? ys[15:0] : xs[15:0];
                w.screen_y = cfg_mode[psb_pkg::MODE_TRANSPOSE] ? xs[15:0] : ys[15:0];
                w.color    = colr;
                w.last     = 1'b0;
                writes_due.push_back(w);
            end
        end
    endtask

    task automatic predict_writes(input psb_pkg::item_t it);
        logic [31:0] s;
        logic [31:0] pairs;
        logic [15:0] hi;
        logic [15:0] lo;
        int          before_cnt;
        psb_pkg::wr_t w;
        case (it.op)
            psb_pkg::OP_PAL:
                palette_copy[it.pal_index] = it.pal_color;
            psb_pkg::OP_RESTART:
            begin
                cur_col_pair = '0;
                cur_row = '0;
            end
            psb_pkg::OP_BYTE:
            begin
                s = (cfg_scale > psb_pkg::MAX_SCALE) ? psb_pkg::MAX_SCALE
                                                     : {29'd0, cfg_scale};
                if (cfg_mode[psb_pkg::MODE_SHOW] && s != 0)
                begin
                    before_cnt = writes_due.size();
                    hi = palette_copy[it.pixel_byte[7:4]];
                    lo = palette_copy[it.pixel_byte[3:0]];
                    if (hi != palette_copy[TRANSPARENT_IDX])
                        expand_pixel({24'd0, cur_col_pair, 1'b0}, {24'd0, cur_row}, s, hi);
                    if (lo != palette_copy[TRANSPARENT_IDX])
                        expand_pixel({24'd0, cur_col_pair, 1'b1}, {24'd0, cur_row}, s, lo);
                    if (writes_due.size() > before_cnt)
                    begin
                        w = writes_due.pop_back();
                        w.last = 1'b1;
                        writes_due.push_back(w);
                    end
                end
                pairs = {24'd0, cfg_width} >> 1;
                if (pairs == 0 || int'(cur_col_pair) + 1 >= int'(pairs))
                begin
                    cur_col_pair = '0;
                    if (cfg_height == 0 || int'(cur_row) + 1 >= int'(cfg_height))
                        cur_row = '0;
                    else
                        cur_row = cur_row + 8'd1;
                end
                else
                    cur_col_pair = cur_col_pair + 7'd1;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input psb_pkg::item_t it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap > 0)
            repeat (gap) @(negedge clk);
        item_data = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predict_writes(it);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    task automatic send_op(input logic [psb_pkg::OP_W-1:0] op, input logic [3:0] idx,
                           input logic [15:0] colr, input logic [7:0] pix);
        psb_pkg::item_t it;
        it.op = op;
        it.pal_index = idx;
        it.pal_color = colr;
        it.pixel_byte = pix;
        send_item(it);
    endtask

    task automatic set_reg(input logic [psb_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            psb_pkg::REG_ORIGIN_X: cfg_origin_x = val;
            psb_pkg::REG_ORIGIN_Y: cfg_origin_y = val;
            psb_pkg::REG_WIDTH:    cfg_width = val[7:0];
            psb_pkg::REG_HEIGHT:   cfg_height = val[7:0];
            psb_pkg::REG_SCALE:    cfg_scale = val[2:0];
            psb_pkg::REG_MODE:     cfg_mode = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (writes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_palette_load();
        int i;
        send_op(psb_pkg::OP_PAL, TRANSPARENT_IDX, 16'h0000, 8'hFF);
        send_op(psb_pkg::OP_PAL, 4'd15, 16'hFFFF, 8'h00);
        // entry 5 shares the transparent color
        send_op(psb_pkg::OP_PAL, 4'd5, 16'h0000, 8'h00);
        for (i = 1; i < psb_pkg::PALETTE_ENTRIES - 1; i++)
            if (i != 5)
                send_op(psb_pkg::OP_PAL, i[3:0], 16'($urandom_range(16'hFFFE, 1)),
                        8'($urandom));
    endtask

    task automatic test_directed_bytes();
        set_reg(psb_pkg::REG_ORIGIN_X, 16'h0000);
        set_reg(psb_pkg::REG_ORIGIN_Y, 16'h0000);
        set_reg(psb_pkg::REG_WIDTH, 16'd4);
        set_reg(psb_pkg::REG_HEIGHT, 16'd2);
        set_reg(psb_pkg::REG_SCALE, 16'd1);
        set_reg(psb_pkg::REG_MODE, 16'd1 << psb_pkg::MODE_SHOW);
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'h00);
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'hFF);
        send_op(psb_pkg::OP_BYTE, 4'hF, 16'hFFFF, 8'h05);
        send_op(OP_UNUSED, 4'hA, 16'h1234, 8'hFF);
        send_op(psb_pkg::OP_RESTART, 4'h3, 16'hFFFF, 8'h77);
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'hE1);
        wait_drained();
    endtask

    task automatic test_draw_modes();
        // coordinate wrap with every flag set at the largest sizes
        set_reg(psb_pkg::REG_ORIGIN_X, 16'hFFFE);
        set_reg(psb_pkg::REG_ORIGIN_Y, 16'hFFFF);
        set_reg(psb_pkg::REG_WIDTH, 16'd254);
        set_reg(psb_pkg::REG_HEIGHT, 16'd255);
        set_reg(psb_pkg::REG_SCALE, 16'd4);
        set_reg(psb_pkg::REG_MODE, 16'hF);
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'hF1);
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'h5F);
        wait_drained();
        set_reg(psb_pkg::REG_SCALE, 16'd0);
        set_reg(psb_pkg::REG_MODE, 16'd1 << psb_pkg::MODE_SHOW);
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'h3C);
        wait_drained();
        set_reg(psb_pkg::REG_SCALE, 16'd7);
        set_reg(psb_pkg::REG_MODE, (16'd1 << psb_pkg::MODE_SHOW)
                                   | (16'd1 << psb_pkg::MODE_FLIP_Y));
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'h12);
        wait_drained();
        set_reg(psb_pkg::REG_WIDTH, 16'd0);
        set_reg(psb_pkg::REG_HEIGHT, 16'd0);
        set_reg(psb_pkg::REG_SCALE, 16'd2);
        set_reg(psb_pkg::REG_MODE, (16'd1 << psb_pkg::MODE_SHOW)
                                   | (16'd1 << psb_pkg::MODE_FLIP_X)
                                   | (16'd1 << psb_pkg::MODE_TRANSPOSE));
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'hA7);
        wait_drained();
        set_reg(psb_pkg::REG_WIDTH, 16'd255);
        set_reg(psb_pkg::REG_HEIGHT, 16'd3);
        set_reg(psb_pkg::REG_MODE, 16'd0);
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'h9E);
        wait_drained();
        set_reg(psb_pkg::REG_MODE, (16'd1 << psb_pkg::MODE_SHOW)
                                   | (16'd1 << psb_pkg::MODE_FLIP_X));
        send_op(psb_pkg::OP_BYTE, 4'd0, 16'h0000, 8'h9E);
        wait_drained();
    endtask

    task automatic random_setup();
        int r;
        r = $urandom_range(3, 0);
        set_reg(psb_pkg::REG_ORIGIN_X,
                (r == 0) ? 16'hFFF0 + 16'($urandom_range(15, 0)) : 16'($urandom));
        r = $urandom_range(3, 0);
        set_reg(psb_pkg::REG_ORIGIN_Y,
                (r == 0) ? 16'hFFF0 + 16'($urandom_range(15, 0)) : 16'($urandom));
        r = $urandom_range(9, 0);
        case (r)
            0: set_reg(psb_pkg::REG_WIDTH, 16'd0);
            1: set_reg(psb_pkg::REG_WIDTH, 16'd254);
            2: set_reg(psb_pkg::REG_WIDTH, 16'd255);
            3: set_reg(psb_pkg::REG_WIDTH, 16'($urandom_range(15, 1)) | 16'd1);
            default: set_reg(psb_pkg::REG_WIDTH, 16'($urandom_range(8, 1) * 2));
        endcase
        r = $urandom_range(7, 0);
        case (r)
            0: set_reg(psb_pkg::REG_HEIGHT, 16'd0);
            1: set_reg(psb_pkg::REG_HEIGHT, 16'd255);
            default: set_reg(psb_pkg::REG_HEIGHT, 16'($urandom_range(6, 1)));
        endcase
        r = $urandom_range(9, 0);
        case (r)
            0: set_reg(psb_pkg::REG_SCALE, 16'd0);
            1: set_reg(psb_pkg::REG_SCALE, 16'($urandom_range(7, 5)));
            2: set_reg(psb_pkg::REG_SCALE, 16'd4);
            default: set_reg(psb_pkg::REG_SCALE, 16'($urandom_range(3, 1)));
        endcase
        if ($urandom_range(99, 0) < 85)
            set_reg(psb_pkg::REG_MODE,
                    16'($urandom_range(15, 0)) | (16'd1 << psb_pkg::MODE_SHOW));
        else
            set_reg(psb_pkg::REG_MODE, 16'($urandom_range(15, 0)));
    endtask

    task automatic test_random_sprites();
        int    p;
        int    counted;
        int    r;
        psb_pkg::item_t it;
        for (p = 0; p < PHASES; p++)
        begin
            // every phase starts from an idle block with all writes seen
            wait_drained();
            tx_calm = ($urandom_range(3, 0) == 0);
            rx_calm = ($urandom_range(3, 0) == 0);
            random_setup();
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = psb_pkg::item_t'($urandom);
                r = $urandom_range(99, 0);
                if (r < 6)
                    it.op = psb_pkg::OP_PAL;
                else if (r < 11)
                    it.op = psb_pkg::OP_RESTART;
                else if (r < 15)
                    it.op = OP_UNUSED;
                else
                    it.op = psb_pkg::OP_BYTE;
                send_item(it);
                if (it.op != OP_UNUSED)
                    counted++;
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // write sink with random back-pressure
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = rx_calm ? 0 : $urandom_range(MAX_GAP, 0);
            if (gap > 0)
            begin
                wr_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            wr_ready = 1'b1;
            do
                @(posedge clk);
            while (!wr_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && wr_valid && wr_ready)
        begin
            if (writes_due.size() == 0)
                report_mismatch("write with none due", wr_data.screen_x, 16'h0000);
            else
            begin
                want_w = writes_due.pop_front();
                if (wr_data.screen_x !== want_w.screen_x)
                    report_mismatch("screen_x", wr_data.screen_x, want_w.screen_x);
                if (wr_data.screen_y !== want_w.screen_y)
                    report_mismatch("screen_y", wr_data.screen_y, want_w.screen_y);
                if (wr_data.color !== want_w.color)
                    report_mismatch("color", wr_data.color, want_w.color);
                if (wr_data.last !== want_w.last)
                    report_mismatch("last", {15'd0, wr_data.last}, {15'd0, want_w.last});
            end
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_palette_load();
        test_directed_bytes();
        test_draw_modes();
        test_random_sprites();
        wait_drained();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
